FILE: hw/rtl/lbp_3x3_pixel_coder_macros.svh
// Assertion macros shared by the lbp checks
`ifndef LBP_3X3_PIXEL_CODER_MACROS_SVH
`define LBP_3X3_PIXEL_CODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbp check failed");

// Next-cycle implication, disabled during reset
`define LBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbp check failed");

`endif

FILE: hw/rtl/lbp_pkg.sv
// Types and constants shared by the lbp pixel coder modules
package lbp_pkg;

    localparam int PX_W       = 8;
    localparam int POS_W      = 11;
    localparam int REG_W      = 12;
    localparam int MAX_HEIGHT = 2048;
    localparam int IMG_W_RST  = 640;
    localparam int IMG_H_RST  = 480;

    typedef logic [PX_W-1:0]  t_px;
    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [0:0] {
        CFG_IMG_WIDTH  = 1'b0,
        CFG_IMG_HEIGHT = 1'b1
    } t_cfg_idx;

    // neighbour weights, [row offset][column offset], top-left first
    localparam t_px W_TAB [3][3] = '{
        '{8'd64, 8'd128, 8'd1},
        '{8'd32, 8'd0,   8'd2},
        '{8'd16, 8'd8,   8'd4}
    };

    // one line store entry: previous row and the row before it
    typedef struct packed {
        t_px a;
        t_px b;
    } t_line_pair;

    // new window column, oldest row first
    typedef struct packed {
        t_px top;
        t_px mid;
        t_px bot;
    } t_column;

    // position of the incoming pixel and the border flags derived from it
    typedef struct packed {
        t_pos row;
        t_pos col;
        logic row_ge1;
        logic row_ge2;
        logic row_last;
        logic col_ge1;
        logic col_ge2;
        logic col_last;
    } t_item;

endpackage

FILE: hw/rtl/lbp_3x3_pixel_coder.sv
// Top level of the 3x3 local binary pattern pixel coder
// Path: pixel -> stage 1 -> window -> output register, where its code word becomes valid.
// Throughput: one pixel per cycle unless stalled; a pixel that closes k codes (k up to 4,
//   more than one only on the last row or column) holds the code stage for all k words.
// Reset: position to (0,0), width 640 (clamped to MAX_WIDTH), height 480; window cleared,
//   line stores are not cleared and need no clearing pass.
module lbp_3x3_pixel_coder #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel words in
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lbp_pkg::PX_W-1:0]    i_pixel,
    // code words out
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lbp_pkg::PX_W-1:0]    o_code,
    output logic [lbp_pkg::POS_W-1:0]   o_out_row,
    output logic [lbp_pkg::POS_W-1:0]   o_out_col,
    output logic                        o_run_last,
    // register writes
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_index,
    input  logic [lbp_pkg::REG_W-1:0]   i_cfg_wdata
);
    import lbp_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RST_W_EFF = (IMG_W_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_W_RST;
    localparam logic [CW-1:0] RST_LAST_COL = CW'(RST_W_EFF - 1);
    localparam t_pos          RST_LAST_ROW = POS_W'(IMG_H_RST - 1);

    // registers hold the last column / row index of the clamped frame size
    logic [CW-1:0] r_last_col;
    logic [CW-1:0] n_last_col;
    t_pos          r_last_row;
    t_pos          n_last_row;
    logic          cfg_restart;

    logic [CW-1:0] r_cur_col;
    t_pos          r_cur_row;

    // stage 1: pixel waits here while its line store entry is read
    logic          r_s1_vld;
    t_item         r_s1_item;
    t_px           r_s1_pix;
    logic [CW-1:0] r_s1_col;

    logic       in_fire;
    logic       s1_adv;
    logic       s2_ready;
    t_line_pair rd_pair;
    t_line_pair wr_pair;
    t_column    new_col;
    t_item      cur_item;

    // --- register writes: clamp width and height, restart the frame
    always_comb begin
        n_last_col  = r_last_col;
        n_last_row  = r_last_row;
        cfg_restart = 1'b0;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMG_WIDTH: begin
                    cfg_restart = 1'b1;
                    if (i_cfg_wdata == '0) begin
                        n_last_col = '0;
                    end else if (int'(i_cfg_wdata) > MAX_WIDTH) begin
                        n_last_col = CW'(MAX_WIDTH - 1);
                    end else begin
                        n_last_col = CW'(i_cfg_wdata - 12'd1);
                    end
                end
                CFG_IMG_HEIGHT: begin
                    cfg_restart = 1'b1;
                    if (i_cfg_wdata == '0) begin
                        n_last_row = '0;
                    end else if (int'(i_cfg_wdata) > MAX_HEIGHT) begin
                        n_last_row = POS_W'(MAX_HEIGHT - 1);
                    end else begin
                        n_last_row = POS_W'(i_cfg_wdata - 12'd1);
                    end
                end
                default: begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    // --- handshake: stage 1 drains into the code stage when it has room
    assign s1_adv  = r_s1_vld && s2_ready;
    assign o_stall = r_s1_vld && !s2_ready;
    assign in_fire = i_valid && !o_stall;

    // --- raster position and border flags of the incoming pixel
    always_comb begin
        cur_item.row      = r_cur_row;
        cur_item.col      = POS_W'(r_cur_col);
        cur_item.row_ge1  = (r_cur_row != '0);
        cur_item.row_ge2  = (r_cur_row > POS_W'(1));
        cur_item.row_last = (r_cur_row == r_last_row);
        cur_item.col_ge1  = (r_cur_col != '0);
        cur_item.col_ge2  = (r_cur_col > CW'(1));
        cur_item.col_last = (r_cur_col == r_last_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= RST_LAST_COL;
            r_last_row <= RST_LAST_ROW;
            r_cur_col  <= '0;
            r_cur_row  <= '0;
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            if (cfg_restart) begin
                r_cur_col <= '0;
                r_cur_row <= '0;
            end else if (in_fire) begin
                // advance along the row, wrap at row and frame end
                if (cur_item.col_last) begin
                    r_cur_col <= '0;
                    r_cur_row <= cur_item.row_last ? '0 : r_cur_row + POS_W'(1);
                end else begin
                    r_cur_col <= r_cur_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_fire) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= cur_item;
            r_s1_pix  <= i_pixel;
            r_s1_col  <= r_cur_col;
        end
    end

    // --- line stores: read on accept, shift the column down on write-back
    assign wr_pair = '{a: r_s1_pix, b: rd_pair.a};
    assign new_col = '{top: rd_pair.b, mid: rd_pair.a, bot: r_s1_pix};

    lbp_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_cur_col),
        .o_rd_data (rd_pair),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_pair)
    );

    // --- window, result sequencing and output register
    lbp_code_unit u_code (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_adv),
        .i_item     (r_s1_item),
        .i_column   (new_col),
        .o_ready    (s2_ready),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_code     (o_code),
        .o_out_row  (o_out_row),
        .o_out_col  (o_out_col),
        .o_run_last (o_run_last)
    );

endmodule

FILE: hw/rtl/lbp_line_mem.sv
// Line store memory: two previous rows per column, registered read with bypass
module lbp_line_mem #(
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output lbp_pkg::t_line_pair      o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  lbp_pkg::t_line_pair      i_wr_data
);
    import lbp_pkg::*;

    t_line_pair r_mem [DEPTH];
    t_line_pair r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // take the word being written when both ports hit the same entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

FILE: hw/rtl/lbp_code_unit.sv
// 3x3 window, result sequencing and code computation with output register
module lbp_code_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lbp_pkg::t_item   i_item,
    input  lbp_pkg::t_column i_column,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output lbp_pkg::t_px     o_code,
    output lbp_pkg::t_pos    o_out_row,
    output lbp_pkg::t_pos    o_out_col,
    output logic             o_run_last
);
    import lbp_pkg::*;

    t_px   r_win [3][3];     // [column age, 2 newest][row, 2 newest]
    t_item r_item;
    logic  r_vld;
    logic  r_ri;
    logic  r_ci;
    logic  r_o_vld;
    t_px   r_o_code;
    t_pos  r_o_row;
    t_pos  r_o_col;
    logic  r_o_last;

    logic       dr;
    logic       dc;
    logic       row_nz;
    logic       col_nz;
    logic [1:0] ridx [3];
    logic [1:0] cidx [3];
    t_px        centre;
    t_px        code;
    logic       ri_end;
    logic       ci_end;
    logic       last;
    logic       fire;
    t_pos       tgt_row;
    t_pos       tgt_col;

    always_comb begin
        // target is one row / column back unless on the far border
        dr     = !r_ri && r_item.row_ge1;
        dc     = !r_ci && r_item.col_ge1;
        row_nz = dr ? r_item.row_ge2 : r_item.row_ge1;
        col_nz = dc ? r_item.col_ge2 : r_item.col_ge1;
        ridx[2] = 2'd2;
        ridx[1] = dr ? 2'd1 : 2'd2;
        ridx[0] = ridx[1] - {1'b0, row_nz};
        cidx[2] = 2'd2;
        cidx[1] = dc ? 2'd1 : 2'd2;
        cidx[0] = cidx[1] - {1'b0, col_nz};
        centre = r_win[cidx[1]][ridx[1]];
        code   = '0;
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                if (r_win[cidx[dx]][ridx[dy]] >= centre) begin
                    code = code | W_TAB[dy][dx];
                end
            end
        end
        tgt_row = r_item.row - {{(POS_W-1){1'b0}}, dr};
        tgt_col = r_item.col - {{(POS_W-1){1'b0}}, dc};
        ri_end  = (r_ri == (r_item.row_ge1 & r_item.row_last));
        ci_end  = (r_ci == (r_item.col_ge1 & r_item.col_last));
        last    = ri_end && ci_end;
        fire    = r_vld && (!r_o_vld || !i_stall);
        o_ready = !r_vld || (fire && last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_ri  <= 1'b0;
            r_ci  <= 1'b0;
            r_win <= '{default: '0};
        end else if (i_load) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= i_column.top;
            r_win[2][1] <= i_column.mid;
            r_win[2][2] <= i_column.bot;
            r_vld <= (i_item.row_ge1 | i_item.row_last) & (i_item.col_ge1 | i_item.col_last);
            r_ri  <= 1'b0;
            r_ci  <= 1'b0;
        end else if (fire) begin
            if (last) begin
                r_vld <= 1'b0;
            end else if (ci_end) begin
                r_ci <= 1'b0;
                r_ri <= 1'b1;
            end else begin
                r_ci <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (fire) begin
            r_o_vld <= 1'b1;
        end else if (!i_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_code <= code;
            r_o_row  <= tgt_row;
            r_o_col  <= tgt_col;
            r_o_last <= last;
        end
    end

    assign o_valid    = r_o_vld;
    assign o_code     = r_o_code;
    assign o_out_row  = r_o_row;
    assign o_out_col  = r_o_col;
    assign o_run_last = r_o_last;

endmodule

FILE: hw/rtl/lbp_chk.sv
// Port-level checks for the lbp pixel coder, bound to the top level
`include "lbp_3x3_pixel_coder_macros.svh"

module lbp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_code,
    input logic [10:0] o_out_row,
    input logic [10:0] o_out_col,
    input logic        o_run_last
);

    // a stalled word stays offered and unchanged
    `LBP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `LBP_ASSERT_NXT(a_word_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_code) && $stable(o_run_last))
    `LBP_ASSERT_NXT(a_pos_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_out_row) && $stable(o_out_col))

    // a run continues without a gap once a non-final word is taken
    `LBP_ASSERT_NXT(a_run_gapless, i_clk, i_rst_n, o_valid && !i_stall && !o_run_last, o_valid)

    // input stall with an empty output register means a word is issued now
    `LBP_ASSERT_NXT(a_stall_emits, i_clk, i_rst_n, o_stall && !o_valid, o_valid)

endmodule

bind lbp_3x3_pixel_coder lbp_chk u_lbp_chk (.*);
